[rtl/dp2w_pkg.sv]
// Shared constants and types for the depth pixel to world point pipeline.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package dp2w_pkg;

  localparam int PIX_W   = 10;
  localparam int DEPTH_W = 16;
  localparam int CLR_W   = 8;
  localparam int ROT_W   = 16;
  localparam int SHIFT_W = 32;
  localparam int WORLD_W = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  // twice the principal point
  localparam int CX_TWICE = 651;
  localparam int CY_TWICE = 507;

  // round(n * 2^SHIFT / DIV) with the odd part of 2*f*1000 (x, y) or of 1000 (z)
  localparam int unsigned CAM_X_DIV    = 32375;
  localparam int unsigned CAM_X_SHIFT  = 15;
  localparam int unsigned CAM_X_BIAS_Q = 1318;
  localparam int unsigned CAM_Y_DIV    = 64875;
  localparam int unsigned CAM_Y_SHIFT  = 16;
  localparam int unsigned CAM_Y_BIAS_Q = 513;
  localparam int unsigned CAM_Z_DIV    = 125;
  localparam int unsigned CAM_Z_SHIFT  = 17;
  localparam int unsigned CAM_Z_BIAS_Q = 0;
  localparam int CAM_X_BIAS = CAM_X_BIAS_Q * CAM_X_DIV;
  localparam int CAM_Y_BIAS = CAM_Y_BIAS_Q * CAM_Y_DIV;

  // biased numerator and camera point (Q.20 metres)
  localparam int NUM_W = 28;
  localparam int CAM_W = 28;

  // rotation matrix entries, Q.28
  localparam int ROT_FRAC = 28;
  localparam int ENT_W    = 34;
  localparam int OUT_SHIFT = 32;

  localparam int RDIV_LAT = 6;
  localparam int DOT_LAT  = 4;
  localparam int PIPE_LAT = 1 + RDIV_LAT + DOT_LAT;

  localparam logic signed [ROT_W-1:0] ROT_W_RST = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_W,
    CFG_ROT_X,
    CFG_ROT_Y,
    CFG_ROT_Z,
    CFG_SHIFT_X,
    CFG_SHIFT_Y,
    CFG_SHIFT_Z
  } cfg_idx_e;

  typedef logic signed [ENT_W-1:0] rot_ent_t;
  typedef rot_ent_t [2:0] rot_row_t;
  typedef rot_row_t [2:0] rot_mat_t;

  typedef logic signed [CAM_W-1:0] cam_t;
  typedef cam_t [2:0] cam_pt_t;

  typedef struct packed {
    logic [CLR_W-1:0] red;
    logic [CLR_W-1:0] green;
    logic [CLR_W-1:0] blue;
  } colour_t;

endpackage

`default_nettype wire

[rtl/dp2w_rdiv.sv]
// Six-stage rounding divider by a fixed odd constant: res = round((num/2^0) * 2^SHIFT / DIV)
// less BIAS_Q * 2^SHIFT. Reciprocal multiplies with one-step corrections. Uses dp2w_pkg.
`default_nettype none

module dp2w_rdiv #(
  parameter int unsigned DIV    = 125,
  parameter int unsigned SHIFT  = 17,
  parameter int unsigned BIAS_Q = 0
) (
  input  wire logic                              clk_i,
  input  wire logic [dp2w_pkg::NUM_W-1:0]        num_i,
  output logic signed [dp2w_pkg::CAM_W-1:0]      res_o
);

  localparam int NW = dp2w_pkg::NUM_W;
  localparam int CW = $clog2(DIV);
  localparam int RW = CW + 1;
  localparam int R2W = CW + 2;
  localparam int TW = CW + SHIFT + 1;
  localparam longint unsigned M1 = (64'd1 << NW) / DIV;
  localparam longint unsigned M2 = (64'd1 << TW) / (2 * DIV);
  localparam int M1W = $clog2(M1 + 1);
  localparam int M2W = $clog2(M2 + 1);
  localparam logic [M1W-1:0] M1V = M1W'(M1);
  localparam logic [M2W-1:0] M2V = M2W'(M2);
  localparam int FW = M1W + SHIFT + 2;

  // stage a
  logic [NW+M1W-1:0] prod1;
  logic [M1W-1:0]    q1e_a_q;
  logic [NW-1:0]     num_a_q;
  // stage b
  logic [NW-1:0]     qc1;
  logic [NW-1:0]     diff1;
  logic [RW-1:0]     r1e_b_q;
  logic [M1W-1:0]    q1e_b_q;
  // stage c
  logic [M1W-1:0]    q1_c_d, q1_c_q;
  logic [CW-1:0]     r1_c;
  logic [TW-1:0]     t_c_d, t_c_q;
  // stage d
  logic [TW+M2W-1:0] prod2;
  logic [M2W-1:0]    q2e_d_q;
  logic [TW-1:0]     t_d_q;
  logic [M1W-1:0]    q1_d_q;
  // stage e
  logic [TW-1:0]     qc2;
  logic [TW-1:0]     diff2;
  logic [R2W-1:0]    r2e_e_q;
  logic [M2W-1:0]    q2e_e_q;
  logic [M1W-1:0]    q1_e_q;
  // stage f
  logic [M2W-1:0]    q2_f;
  logic signed [FW-1:0] qs_f, full_f;
  logic signed [dp2w_pkg::CAM_W-1:0] res_q;

  assign prod1 = num_i * M1V;
  assign qc1   = q1e_a_q * NW'(DIV);
  assign diff1 = num_a_q - qc1;

  always_comb begin
    if (r1e_b_q >= RW'(DIV)) begin
      q1_c_d = q1e_b_q + M1W'(1);
      r1_c   = CW'(r1e_b_q - RW'(DIV));
    end else begin
      q1_c_d = q1e_b_q;
      r1_c   = CW'(r1e_b_q);
    end
    t_c_d = (TW'(r1_c) << (SHIFT + 1)) + TW'(DIV);
  end

  assign prod2 = t_c_q * M2V;
  assign qc2   = TW'(q2e_d_q * TW'(2 * DIV));
  assign diff2 = t_d_q - qc2;

  assign q2_f   = q2e_e_q + M2W'(r2e_e_q >= R2W'(2 * DIV));
  assign qs_f   = $signed(FW'(q1_e_q)) - $signed(FW'(BIAS_Q));
  assign full_f = (qs_f <<< SHIFT) + $signed(FW'(q2_f));

  always_ff @(posedge clk_i) begin
    q1e_a_q <= prod1[NW+M1W-1:NW];
    num_a_q <= num_i;
    r1e_b_q <= diff1[RW-1:0];
    q1e_b_q <= q1e_a_q;
    q1_c_q  <= q1_c_d;
    t_c_q   <= t_c_d;
    q2e_d_q <= prod2[TW+M2W-1:TW];
    t_d_q   <= t_c_q;
    q1_d_q  <= q1_c_q;
    r2e_e_q <= diff2[R2W-1:0];
    q2e_e_q <= q2e_d_q;
    q1_e_q  <= q1_d_q;
    res_q   <= dp2w_pkg::CAM_W'(full_f);
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[rtl/dp2w_rotmat.sv]
// Builds the Q.28 rotation matrix from the Q1.14 quaternion registers.
// Two register stages (products, then entries). Uses dp2w_pkg.
`default_nettype none

module dp2w_rotmat (
  input  wire logic                                clk_i,
  input  wire logic signed [dp2w_pkg::ROT_W-1:0]   rot_w_i,
  input  wire logic signed [dp2w_pkg::ROT_W-1:0]   rot_x_i,
  input  wire logic signed [dp2w_pkg::ROT_W-1:0]   rot_y_i,
  input  wire logic signed [dp2w_pkg::ROT_W-1:0]   rot_z_i,
  output dp2w_pkg::rot_mat_t                       mat_o
);

  localparam int PW = 2 * dp2w_pkg::ROT_W;
  localparam int EW = dp2w_pkg::ENT_W;
  localparam logic signed [EW-1:0] ONE = EW'(1) <<< dp2w_pkg::ROT_FRAC;

  logic signed [PW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  dp2w_pkg::rot_mat_t mat_d, mat_q;

  always_ff @(posedge clk_i) begin
    xx_q <= rot_x_i * rot_x_i;
    yy_q <= rot_y_i * rot_y_i;
    zz_q <= rot_z_i * rot_z_i;
    xy_q <= rot_x_i * rot_y_i;
    xz_q <= rot_x_i * rot_z_i;
    yz_q <= rot_y_i * rot_z_i;
    wx_q <= rot_w_i * rot_x_i;
    wy_q <= rot_w_i * rot_y_i;
    wz_q <= rot_w_i * rot_z_i;
  end

  always_comb begin
    mat_d[0][0] = ONE - ((EW'(yy_q) + EW'(zz_q)) <<< 1);
    mat_d[0][1] = (EW'(xy_q) - EW'(wz_q)) <<< 1;
    mat_d[0][2] = (EW'(xz_q) + EW'(wy_q)) <<< 1;
    mat_d[1][0] = (EW'(xy_q) + EW'(wz_q)) <<< 1;
    mat_d[1][1] = ONE - ((EW'(xx_q) + EW'(zz_q)) <<< 1);
    mat_d[1][2] = (EW'(yz_q) - EW'(wx_q)) <<< 1;
    mat_d[2][0] = (EW'(xz_q) - EW'(wy_q)) <<< 1;
    mat_d[2][1] = (EW'(yz_q) + EW'(wx_q)) <<< 1;
    mat_d[2][2] = ONE - ((EW'(xx_q) + EW'(yy_q)) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    mat_q <= mat_d;
  end

  assign mat_o = mat_q;

endmodule

`default_nettype wire

[rtl/dp2w_rowdot.sv]
// One row of the rigid transform: dot product of a matrix row with the camera
// point, rounded to Q16.16, translated and saturated. Four stages. Uses dp2w_pkg.
`default_nettype none

module dp2w_rowdot (
  input  wire logic                                 clk_i,
  input  wire dp2w_pkg::rot_row_t                   row_i,
  input  wire dp2w_pkg::cam_pt_t                    pt_i,
  input  wire logic signed [dp2w_pkg::SHIFT_W-1:0]  shift_i,
  output logic signed [dp2w_pkg::WORLD_W-1:0]       world_o
);

  localparam int EW    = dp2w_pkg::ENT_W;
  localparam int LO_W  = 17;
  localparam int PL_W  = LO_W + 1 + dp2w_pkg::CAM_W;
  localparam int PH_W  = EW - LO_W + dp2w_pkg::CAM_W;
  localparam int SL_W  = PL_W + 2;
  localparam int SH_W  = PH_W + 2;
  localparam int SUM_W = 64;
  localparam int OW    = dp2w_pkg::WORLD_W;
  localparam int XW    = dp2w_pkg::SHIFT_W + 2;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (dp2w_pkg::OUT_SHIFT - 1);
  localparam logic signed [XW-1:0] SAT_HI = XW'((64'sd1 <<< (OW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

  logic signed [PL_W-1:0]  lo_d [3];
  logic signed [PH_W-1:0]  hi_d [3];
  logic signed [PL_W-1:0]  lo_q [3];
  logic signed [PH_W-1:0]  hi_q [3];
  logic signed [SL_W-1:0]  slo_q;
  logic signed [SH_W-1:0]  shi_q;
  logic signed [SUM_W-1:0] sum_d, sum_q;
  logic signed [OW-1:0]    rnd_v;
  logic signed [XW-1:0]    ext_v;
  logic signed [OW-1:0]    world_d, world_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo_d[k] = $signed({1'b0, row_i[k][LO_W-1:0]}) * $signed(pt_i[k]);
      hi_d[k] = $signed(row_i[k][EW-1:LO_W]) * $signed(pt_i[k]);
    end
  end

  assign sum_d = (SUM_W'(shi_q) <<< LO_W) + SUM_W'(slo_q) + RND;
  assign rnd_v = sum_q[SUM_W-1:dp2w_pkg::OUT_SHIFT];
  assign ext_v = XW'(rnd_v) + XW'(shift_i);

  always_comb begin
    if (ext_v > SAT_HI) begin
      world_d = OW'(SAT_HI);
    end else if (ext_v < SAT_LO) begin
      world_d = OW'(SAT_LO);
    end else begin
      world_d = OW'(ext_v);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      lo_q[k] <= lo_d[k];
      hi_q[k] <= hi_d[k];
    end
    slo_q   <= SL_W'(lo_q[0]) + SL_W'(lo_q[1]) + SL_W'(lo_q[2]);
    shi_q   <= SH_W'(hi_q[0]) + SH_W'(hi_q[1]) + SH_W'(hi_q[2]);
    sum_q   <= sum_d;
    world_q <= world_d;
  end

  assign world_o = world_q;

endmodule

`default_nettype wire

[rtl/depth_pixel_to_world_point.sv]
// Top level: RGB-D pixel back-projection and rigid transform to world points.
// Instantiates dp2w_rdiv, dp2w_rotmat and dp2w_rowdot; uses dp2w_pkg.
//
// Usage:
//   Input: an item (col, row, depth, colour) is taken at a rising edge with
//   start_i high and busy_o low. busy_o is never raised, so one item can be
//   taken every cycle.
//   Output: done_o marks a result for exactly one cycle; the receiver cannot
//   stall, and none is needed since the pipeline never holds.
//   A zero depth or a pixel outside MAX_COLS x MAX_ROWS gives no result.
//   Path: an accepted item passes the input register, the constant-divider
//   pipeline and the dot-product pipeline, in that order.
//   Throughput: one item per cycle, sustained.
//   Configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i write one register per
//   cycle; write only when idle. The rotation matrix follows a write through
//   the product and entry registers of dp2w_rotmat.
//   Reset: clears the valid line and loads the identity pose; items in flight
//   are dropped.
`default_nettype none

module depth_pixel_to_world_point #(
  parameter int MAX_COLS = dp2w_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = dp2w_pkg::MAX_ROWS_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [dp2w_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [dp2w_pkg::CFG_W-1:0]              cfg_wdata_i,
  input  wire logic                                    start_i,
  output logic                                         busy_o,
  input  wire logic [dp2w_pkg::PIX_W-1:0]              col_i,
  input  wire logic [dp2w_pkg::PIX_W-1:0]              row_i,
  input  wire logic [dp2w_pkg::DEPTH_W-1:0]            depth_raw_i,
  input  wire logic [dp2w_pkg::CLR_W-1:0]              red_in_i,
  input  wire logic [dp2w_pkg::CLR_W-1:0]              green_in_i,
  input  wire logic [dp2w_pkg::CLR_W-1:0]              blue_in_i,
  output logic                                         done_o,
  output logic signed [dp2w_pkg::WORLD_W-1:0]          world_x_o,
  output logic signed [dp2w_pkg::WORLD_W-1:0]          world_y_o,
  output logic signed [dp2w_pkg::WORLD_W-1:0]          world_z_o,
  output logic [dp2w_pkg::CLR_W-1:0]                   red_out_o,
  output logic [dp2w_pkg::CLR_W-1:0]                   green_out_o,
  output logic [dp2w_pkg::CLR_W-1:0]                   blue_out_o
);

  localparam int LAT   = dp2w_pkg::PIPE_LAT;
  localparam int PW    = dp2w_pkg::PIX_W;
  localparam int COL_W = (PW > $clog2(MAX_COLS + 1)) ? PW : $clog2(MAX_COLS + 1);
  localparam int ROW_W = (PW > $clog2(MAX_ROWS + 1)) ? PW : $clog2(MAX_ROWS + 1);
  localparam int DX_W  = PW + 3;
  localparam int PR_W  = DX_W + dp2w_pkg::DEPTH_W + 1;
  localparam int NW    = dp2w_pkg::NUM_W;

  // configuration registers
  logic signed [dp2w_pkg::ROT_W-1:0]   rot_w_q, rot_x_q, rot_y_q, rot_z_q;
  logic signed [dp2w_pkg::SHIFT_W-1:0] shift_x_q, shift_y_q, shift_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_w_q   <= dp2w_pkg::ROT_W_RST;
      rot_x_q   <= '0;
      rot_y_q   <= '0;
      rot_z_q   <= '0;
      shift_x_q <= '0;
      shift_y_q <= '0;
      shift_z_q <= '0;
    end else if (cfg_we_i) begin
      case (dp2w_pkg::cfg_idx_e'(cfg_idx_i))
        dp2w_pkg::CFG_ROT_W:   rot_w_q   <= cfg_wdata_i[dp2w_pkg::ROT_W-1:0];
        dp2w_pkg::CFG_ROT_X:   rot_x_q   <= cfg_wdata_i[dp2w_pkg::ROT_W-1:0];
        dp2w_pkg::CFG_ROT_Y:   rot_y_q   <= cfg_wdata_i[dp2w_pkg::ROT_W-1:0];
        dp2w_pkg::CFG_ROT_Z:   rot_z_q   <= cfg_wdata_i[dp2w_pkg::ROT_W-1:0];
        dp2w_pkg::CFG_SHIFT_X: shift_x_q <= cfg_wdata_i[dp2w_pkg::SHIFT_W-1:0];
        dp2w_pkg::CFG_SHIFT_Y: shift_y_q <= cfg_wdata_i[dp2w_pkg::SHIFT_W-1:0];
        dp2w_pkg::CFG_SHIFT_Z: shift_z_q <= cfg_wdata_i[dp2w_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic                    accept;
  logic                    keep;
  logic signed [DX_W-1:0]  dx, dy;
  logic signed [PR_W-1:0]  prod_x, prod_y, sum_x, sum_y;
  logic [NW-1:0]           numx_q, numy_q, numz_q;
  logic [LAT-1:0]          vld_q;
  dp2w_pkg::colour_t       clr_q [LAT];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign keep   = accept && (depth_raw_i != '0)
                  && (COL_W'(col_i) < COL_W'(MAX_COLS))
                  && (ROW_W'(row_i) < ROW_W'(MAX_ROWS));

  assign dx     = $signed({2'b00, col_i, 1'b0}) - $signed(DX_W'(dp2w_pkg::CX_TWICE));
  assign dy     = $signed({2'b00, row_i, 1'b0}) - $signed(DX_W'(dp2w_pkg::CY_TWICE));
  assign prod_x = dx * $signed({1'b0, depth_raw_i});
  assign prod_y = dy * $signed({1'b0, depth_raw_i});
  assign sum_x  = prod_x + $signed(PR_W'(dp2w_pkg::CAM_X_BIAS));
  assign sum_y  = prod_y + $signed(PR_W'(dp2w_pkg::CAM_Y_BIAS));

  always_ff @(posedge clk_i) begin
    numx_q   <= sum_x[NW-1:0];
    numy_q   <= sum_y[NW-1:0];
    numz_q   <= NW'(depth_raw_i);
    clr_q[0] <= '{red: red_in_i, green: green_in_i, blue: blue_in_i};
    for (int k = 1; k < LAT; k++) begin
      clr_q[k] <= clr_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], keep};
    end
  end

  // camera point
  dp2w_pkg::cam_pt_t cam_pt;

  dp2w_rdiv #(
    .DIV   (dp2w_pkg::CAM_X_DIV),
    .SHIFT (dp2w_pkg::CAM_X_SHIFT),
    .BIAS_Q(dp2w_pkg::CAM_X_BIAS_Q)
  ) u_div_x (
    .clk_i(clk_i),
    .num_i(numx_q),
    .res_o(cam_pt[0])
  );

  dp2w_rdiv #(
    .DIV   (dp2w_pkg::CAM_Y_DIV),
    .SHIFT (dp2w_pkg::CAM_Y_SHIFT),
    .BIAS_Q(dp2w_pkg::CAM_Y_BIAS_Q)
  ) u_div_y (
    .clk_i(clk_i),
    .num_i(numy_q),
    .res_o(cam_pt[1])
  );

  dp2w_rdiv #(
    .DIV   (dp2w_pkg::CAM_Z_DIV),
    .SHIFT (dp2w_pkg::CAM_Z_SHIFT),
    .BIAS_Q(dp2w_pkg::CAM_Z_BIAS_Q)
  ) u_div_z (
    .clk_i(clk_i),
    .num_i(numz_q),
    .res_o(cam_pt[2])
  );

  // rigid transform
  dp2w_pkg::rot_mat_t rot_mat;

  dp2w_rotmat u_rotmat (
    .clk_i  (clk_i),
    .rot_w_i(rot_w_q),
    .rot_x_i(rot_x_q),
    .rot_y_i(rot_y_q),
    .rot_z_i(rot_z_q),
    .mat_o  (rot_mat)
  );

  dp2w_rowdot u_dot_x (
    .clk_i  (clk_i),
    .row_i  (rot_mat[0]),
    .pt_i   (cam_pt),
    .shift_i(shift_x_q),
    .world_o(world_x_o)
  );

  dp2w_rowdot u_dot_y (
    .clk_i  (clk_i),
    .row_i  (rot_mat[1]),
    .pt_i   (cam_pt),
    .shift_i(shift_y_q),
    .world_o(world_y_o)
  );

  dp2w_rowdot u_dot_z (
    .clk_i  (clk_i),
    .row_i  (rot_mat[2]),
    .pt_i   (cam_pt),
    .shift_i(shift_z_q),
    .world_o(world_z_o)
  );

  assign done_o      = vld_q[LAT-1];
  assign red_out_o   = clr_q[LAT-1].red;
  assign green_out_o = clr_q[LAT-1].green;
  assign blue_out_o  = clr_q[LAT-1].blue;

  // a result only ever follows an accepted item with a nonzero depth
  a_done_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o && (depth_raw_i != '0), LAT))
    else $error("result without a matching item");

  // colour travels in step with the arithmetic
  a_colour_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (red_out_o == $past(red_in_i, LAT)) && (green_out_o == $past(green_in_i, LAT))
               && (blue_out_o == $past(blue_in_i, LAT)))
    else $error("colour out of step with result");

  // pixels outside the image never produce a result
  a_range_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past((COL_W'(col_i) < COL_W'(MAX_COLS)) && (ROW_W'(row_i) < ROW_W'(MAX_ROWS)), LAT))
    else $error("result for pixel outside image");

endmodule

`default_nettype wire

[tb/sv/depth_pixel_to_world_point_tb.sv]
// Testbench for depth_pixel_to_world_point: RGB-D pixels in, world points out.
// Self-checking against an in-bench fixed-point projection and pose model;
// depends on dp2w_pkg and the block's RTL only.
`timescale 1ns / 1ps

module depth_pixel_to_world_point_tb;
  import dp2w_pkg::*;

  localparam int     IMG_COLS    = MAX_COLS_DEF;
  localparam int     IMG_ROWS    = MAX_ROWS_DEF;
  localparam longint FOCAL_X     = 518;
  localparam longint FOCAL_Y     = 519;
  localparam longint DEPTH_PER_M = 1000;
  localparam int     CAM_FRAC    = 20;
  localparam longint ROT_UNITY   = longint'(1) << ROT_FRAC;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int     NUM_POSES   = 8;
  localparam int     ITEMS_PER_POSE = 212;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     MAX_PRINTED = 40;

  typedef struct packed {
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   row;
    logic [DEPTH_W-1:0] depth;
    colour_t            clr;
  } pixel_t;

  typedef struct packed {
    logic signed [WORLD_W-1:0] x;
    logic signed [WORLD_W-1:0] y;
    logic signed [WORLD_W-1:0] z;
    colour_t                   clr;
  } point_t;

  typedef struct packed {
    pixel_t pix;
    bit     typed;
    logic signed [WORLD_W-1:0] x;
    logic signed [WORLD_W-1:0] y;
    logic signed [WORLD_W-1:0] z;
  } pix_case_t;

  // Identity pose after reset. A depth of 32375 makes the camera point exact:
  // x = (2u-651)*2048, and at row 513 y = 1060864, z = 2121728 always.
  localparam int NUM_DIRECTED = 20;
  pix_case_t directed_cases [NUM_DIRECTED] = '{
    '{'{10'd0,    10'd513,  16'd32375, 24'h000000}, 1'b1, -32'sd1333248, 32'sd1060864,
      32'sd2121728},
    '{'{10'd1023, 10'd513,  16'd32375, 24'hFFFFFF}, 1'b1, 32'sd2856960,  32'sd1060864,
      32'sd2121728},
    '{'{10'd325,  10'd513,  16'd32375, 24'h55AA01}, 1'b1, -32'sd2048,    32'sd1060864,
      32'sd2121728},
    '{'{10'd326,  10'd513,  16'd32375, 24'hAA5580}, 1'b1, 32'sd2048,     32'sd1060864,
      32'sd2121728},
    '{'{10'd0,    10'd0,    16'd0,     24'h123456}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd1023, 10'd1023, 16'd0,     24'hFFFFFF}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd0,    10'd0,    16'd65535, 24'h010203}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd1023, 10'd1023, 16'd65535, 24'hFEFDFC}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd0,    10'd1023, 16'd65535, 24'h800000}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd1023, 10'd0,    16'd65535, 24'h008000}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd0,    10'd0,    16'd1,     24'h000080}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd1023, 10'd1023, 16'd1,     24'h7F7F7F}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd512,  10'd512,  16'd1,     24'hC0FFEE}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd325,  10'd253,  16'd1000,  24'h0F0F0F}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd326,  10'd254,  16'd1000,  24'hF0F0F0}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'h2AA,  10'h155,  16'hAAAA,  24'hAAAAAA}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'h155,  10'h2AA,  16'h5555,  24'h555555}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd640,  10'd480,  16'd0,     24'h00FF00}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd640,  10'd480,  16'd4500,  24'hFF00FF}, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{'{10'd1,    10'd1,    16'd32768, 24'h804020}, 1'b0, 32'sd0, 32'sd0, 32'sd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [PIX_W-1:0] col_i = '0;
  logic [PIX_W-1:0] row_i = '0;
  logic [DEPTH_W-1:0] depth_raw_i = '0;
  logic [CLR_W-1:0] red_in_i = '0;
  logic [CLR_W-1:0] green_in_i = '0;
  logic [CLR_W-1:0] blue_in_i = '0;
  logic done_o;
  logic signed [WORLD_W-1:0] world_x_o;
  logic signed [WORLD_W-1:0] world_y_o;
  logic signed [WORLD_W-1:0] world_z_o;
  logic [CLR_W-1:0] red_out_o;
  logic [CLR_W-1:0] green_out_o;
  logic [CLR_W-1:0] blue_out_o;

  // pose as the block should hold it
  logic signed [ROT_W-1:0]   quat_w = ROT_W_RST;
  logic signed [ROT_W-1:0]   quat_x = '0;
  logic signed [ROT_W-1:0]   quat_y = '0;
  logic signed [ROT_W-1:0]   quat_z = '0;
  logic signed [SHIFT_W-1:0] trans_x = '0;
  logic signed [SHIFT_W-1:0] trans_y = '0;
  logic signed [SHIFT_W-1:0] trans_z = '0;

  point_t points_due [$];
  int errors = 0;
  int pixels_sent = 0;
  int pixels_blank = 0;
  int points_checked = 0;
  int cycles = 0;

  depth_pixel_to_world_point dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .col_i       (col_i),
    .row_i       (row_i),
    .depth_raw_i (depth_raw_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .done_o      (done_o),
    .world_x_o   (world_x_o),
    .world_y_o   (world_y_o),
    .world_z_o   (world_z_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points outstanding", cycles, points_due.size());
      $display("depth_pixel_to_world_point test failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (errors < MAX_PRINTED)
      $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // append a predicted point behind the ones already due
  function automatic void queue_point(input point_t p);
    points_due = {points_due, p};
  endfunction

  function automatic longint floor_div(input longint n, input longint d);
    if (n >= 0)
      return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // nearest, ties towards plus infinity
  function automatic longint round_div(input longint n, input longint d);
    return floor_div(2 * n + d, 2 * d);
  endfunction

  function automatic logic signed [WORLD_W-1:0] to_world(input longint acc, input longint t);
    longint v;
    v = ((acc + (longint'(1) << 31)) >>> OUT_SHIFT) + t;
    if (v > longint'(32'h7FFF_FFFF))
      v = longint'(32'h7FFF_FFFF);
    if (v < -(longint'(1) << 31))
      v = -(longint'(1) << 31);
    return v[WORLD_W-1:0];
  endfunction

  function automatic bit project_pixel(input pixel_t p, output point_t pt);
    longint u, v, d, px, py, pz, w, x, y, z;
    longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
    u = longint'(p.col);
    v = longint'(p.row);
    d = longint'(p.depth);
    pt = '0;
    if (d == 0 || u >= IMG_COLS || v >= IMG_ROWS)
      return 1'b0;
    px = round_div((2 * u - CX_TWICE) * d * (longint'(1) << CAM_FRAC),
                   2 * FOCAL_X * DEPTH_PER_M);
    py = round_div((2 * v - CY_TWICE) * d * (longint'(1) << CAM_FRAC),
                   2 * FOCAL_Y * DEPTH_PER_M);
    pz = round_div(d * (longint'(1) << CAM_FRAC), DEPTH_PER_M);
    w = longint'(quat_w);
    x = longint'(quat_x);
    y = longint'(quat_y);
    z = longint'(quat_z);
    r00 = ROT_UNITY - 2 * (y * y + z * z);
    r01 = 2 * (x * y - w * z);
    r02 = 2 * (x * z + w * y);
    r10 = 2 * (x * y + w * z);
    r11 = ROT_UNITY - 2 * (x * x + z * z);
    r12 = 2 * (y * z - w * x);
    r20 = 2 * (x * z - w * y);
    r21 = 2 * (y * z + w * x);
    r22 = ROT_UNITY - 2 * (x * x + y * y);
    pt.x = to_world(r00 * px + r01 * py + r02 * pz, longint'(trans_x));
    pt.y = to_world(r10 * px + r11 * py + r12 * pz, longint'(trans_y));
    pt.z = to_world(r20 * px + r21 * py + r22 * pz, longint'(trans_z));
    pt.clr = p.clr;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (points_due.size() == 0) begin
        flag_mismatch("point with nothing outstanding, world_x", longint'(world_x_o), 0);
      end else begin
        want = points_due.pop_front();
        points_checked++;
        if (world_x_o !== want.x)
          flag_mismatch("world_x", longint'(world_x_o), longint'(want.x));
        if (world_y_o !== want.y)
          flag_mismatch("world_y", longint'(world_y_o), longint'(want.y));
        if (world_z_o !== want.z)
          flag_mismatch("world_z", longint'(world_z_o), longint'(want.z));
        if (red_out_o !== want.clr.red)
          flag_mismatch("red", longint'(red_out_o), longint'(want.clr.red));
        if (green_out_o !== want.clr.green)
          flag_mismatch("green", longint'(green_out_o), longint'(want.clr.green));
        if (blue_out_o !== want.clr.blue)
          flag_mismatch("blue", longint'(blue_out_o), longint'(want.clr.blue));
      end
    end
  end

  // leaves start high; returns at the edge that takes the item
  task automatic send_pixel(input pixel_t p);
    start_i     <= 1'b1;
    col_i       <= p.col;
    row_i       <= p.row;
    depth_raw_i <= p.depth;
    red_in_i    <= p.clr.red;
    green_in_i  <= p.clr.green;
    blue_in_i   <= p.clr.blue;
    @(posedge clk_i);
    while (busy_o !== 1'b0)
      @(posedge clk_i);
    pixels_sent++;
    if (p.depth == 0)
      pixels_blank++;
  endtask

  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(99) < 7) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // blank pixels leave no trace, so also let the pipeline drain after the last point
  task automatic settle_pipeline();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (points_due.size() != 0)
      @(posedge clk_i);
    repeat (PIPE_LAT + 3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ROT_W:   quat_w  = data[ROT_W-1:0];
      CFG_ROT_X:   quat_x  = data[ROT_W-1:0];
      CFG_ROT_Y:   quat_y  = data[ROT_W-1:0];
      CFG_ROT_Z:   quat_z  = data[ROT_W-1:0];
      CFG_SHIFT_X: trans_x = data;
      CFG_SHIFT_Y: trans_y = data;
      CFG_SHIFT_Z: trans_z = data;
      default: ;
    endcase
  endtask

  // upper half of the data bus is noise for the quaternion registers
  task automatic write_pose(input logic [ROT_W-1:0] w, input logic [ROT_W-1:0] x,
                            input logic [ROT_W-1:0] y, input logic [ROT_W-1:0] z,
                            input logic [SHIFT_W-1:0] sx, input logic [SHIFT_W-1:0] sy,
                            input logic [SHIFT_W-1:0] sz);
    write_reg(CFG_ROT_W, {16'($urandom), w});
    write_reg(CFG_ROT_X, {16'($urandom), x});
    write_reg(CFG_ROT_Y, {16'($urandom), y});
    write_reg(CFG_ROT_Z, {16'($urandom), z});
    write_reg(CFG_SHIFT_X, sx);
    write_reg(CFG_SHIFT_Y, sy);
    write_reg(CFG_SHIFT_Z, sz);
    write_reg(CFG_UNUSED, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [SHIFT_W-1:0] near_shift();
    return SHIFT_W'(int'($urandom_range(1310720)) - 655360);
  endfunction

  initial begin
    pixel_t pix;
    point_t pt;
    int pick;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_pixel(directed_cases[i].pix);
      if (directed_cases[i].typed) begin
        pt.x = directed_cases[i].x;
        pt.y = directed_cases[i].y;
        pt.z = directed_cases[i].z;
        pt.clr = directed_cases[i].pix.clr;
        queue_point(pt);
      end else if (project_pixel(directed_cases[i].pix, pt)) begin
        queue_point(pt);
      end
      maybe_idle(1'b1);
    end

    for (int pose = 0; pose < NUM_POSES; pose++) begin
      settle_pipeline();
      case (pose)
        0: write_pose(16'sd16384, '0, '0, '0, near_shift(), near_shift(), near_shift());
        // quarter turn about z
        1: write_pose(16'sd11585, '0, '0, 16'sd11585, near_shift(), near_shift(),
                      near_shift());
        2: write_pose(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF);
        3: write_pose(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000);
        // half turn about x
        4: write_pose('0, 16'sd16384, '0, '0, near_shift(), $urandom, near_shift());
        5: write_pose(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192, near_shift(),
                      near_shift(), near_shift());
        6: write_pose(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      $urandom, $urandom, $urandom);
        default: write_pose(16'($urandom_range(16384)), 16'($urandom), 16'($urandom),
                            16'($urandom), 32'h7FFF_0000, 32'h8000_FFFF, $urandom);
      endcase
      for (int i = 0; i < ITEMS_PER_POSE; i++) begin
        pick = $urandom_range(99);
        pix.col = PIX_W'($urandom_range(IMG_COLS - 1));
        pix.row = PIX_W'($urandom_range(IMG_ROWS - 1));
        if (pick < 10)
          pix.depth = '0;
        else if (pick < 30)
          pix.depth = DEPTH_W'($urandom_range(1, 2000));
        else if (pick < 40)
          pix.depth = DEPTH_W'($urandom_range(60000, 65535));
        else
          pix.depth = DEPTH_W'($urandom_range(1, 65535));
        pix.clr = 24'($urandom);
        send_pixel(pix);
        if (project_pixel(pix, pt))
          queue_point(pt);
        // the quarter-turn pose runs back to back
        maybe_idle(pose != 1);
      end
    end

    settle_pipeline();
    $display("%0d pixels sent (%0d with no depth) over %0d poses plus the reset pose",
             pixels_sent, pixels_blank, NUM_POSES);
    $display("%0d world points checked, %0d mismatches", points_checked, errors);
    if (errors == 0 && points_due.size() == 0) begin
      $display("depth_pixel_to_world_point test passed");
    end else begin
      $display("depth_pixel_to_world_point test failed");
    end
    $finish;
  end

endmodule
